@@ rtl/core/bhs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bhs_pkg;

  localparam int FracBitsDef = 16;

  localparam int CoordW   = 32;
  localparam int HeightW  = 32;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int DimW     = 16;

  localparam logic [CfgAddrW-1:0] RegOriginX = 3'd0;
  localparam logic [CfgAddrW-1:0] RegOriginY = 3'd1;
  localparam logic [CfgAddrW-1:0] RegInvCell = 3'd2;
  localparam logic [CfgAddrW-1:0] RegGridW   = 3'd3;
  localparam logic [CfgAddrW-1:0] RegGridH   = 3'd4;
  localparam logic [CfgAddrW-1:0] RegNodata  = 3'd5;

  localparam logic [CoordW-1:0]  OriginRst  = 32'd0;
  localparam logic [31:0]        InvCellRst = 32'd65536;
  localparam logic [DimW-1:0]    GridDimRst = 16'd1024;
  localparam logic [HeightW-1:0] NodataRst  = 32'h8000_0000;

endpackage

`default_nettype wire

@@ rtl/core/bilinear_height_sampler_nodata.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat passes the six register stages before its master-side result.
// Throughput: one beat per cycle; the six register stages advance together and
// freeze as a whole while the output beat is held by m_axis_tready low.
// The multipliers sit in the grid mapping, row product and column product stages.
// Reset clears all valid bits and loads the configuration registers with their defaults.

module bilinear_height_sampler_nodata #(
  parameter int FracBits = bhs_pkg::FracBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bhs_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [bhs_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // world_x, world_y, corner_00, corner_10, corner_01, corner_11
  input  wire logic [191:0]                  s_axis_tdata,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // height
  output      logic [bhs_pkg::HeightW-1:0]   m_axis_tdata,
  // out_of_bounds, used_nearest
  output      logic [1:0]                    m_axis_tuser
);
  import bhs_pkg::*;

  localparam int PW   = HeightW + FracBits + 2;
  localparam int SqW  = 2 * FracBits + 1;
  localparam int DW   = 2 * FracBits + 2;
  localparam logic [FracBits:0] One  = (FracBits+1)'(1) << FracBits;
  localparam logic signed [PW:0] Half = (PW+1)'(1) << (FracBits - 1);

  // configuration
  logic signed [CoordW-1:0]  base_x_q, base_y_q, nodata_q;
  logic        [31:0]        inv_cell_q;
  logic        [DimW-1:0]    grid_w_q, grid_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q   <= OriginRst;
      base_y_q   <= OriginRst;
      inv_cell_q <= InvCellRst;
      grid_w_q   <= GridDimRst;
      grid_h_q   <= GridDimRst;
      nodata_q   <= NodataRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegOriginX: base_x_q   <= cfg_data_i;
        RegOriginY: base_y_q   <= cfg_data_i;
        RegInvCell: inv_cell_q <= cfg_data_i;
        RegGridW:   grid_w_q   <= cfg_data_i[DimW-1:0];
        RegGridH:   grid_h_q   <= cfg_data_i[DimW-1:0];
        RegNodata:  nodata_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;

  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vo_q <= v5_q;
    end
  end

  // stage 1: offsets, nodata match
  logic signed [HeightW-1:0] in_h [4];
  logic signed [CoordW-1:0]  in_wx, in_wy;
  logic signed [CoordW:0]    s1_dx_q, s1_dy_q;
  logic signed [HeightW-1:0] s1_h_q [4];
  logic [3:0]                s1_nd_q;

  assign in_wx = s_axis_tdata[31:0];
  assign in_wy = s_axis_tdata[63:32];
  for (genvar g = 0; g < 4; g++) begin : g_in
    assign in_h[g] = s_axis_tdata[64 + 32*g +: 32];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q <= {in_wx[CoordW-1], in_wx} - {base_x_q[CoordW-1], base_x_q};
      s1_dy_q <= {base_y_q[CoordW-1], base_y_q} - {in_wy[CoordW-1], in_wy};
      for (int i = 0; i < 4; i++) begin
        s1_h_q[i]  <= in_h[i];
        s1_nd_q[i] <= (in_h[i] == nodata_q);
      end
    end
  end

  // stage 2: grid mapping products
  logic [31:0]               dmag_x, dmag_y;
  logic [63:0]               s2_px_q, s2_py_q;
  logic                      s2_negx_q, s2_negy_q;
  logic signed [HeightW-1:0] s2_h_q [4];
  logic [3:0]                s2_nd_q;

  assign dmag_x = s1_dx_q[CoordW] ? 32'd0 : s1_dx_q[31:0];
  assign dmag_y = s1_dy_q[CoordW] ? 32'd0 : s1_dy_q[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_px_q   <= {32'd0, dmag_x} * {32'd0, inv_cell_q};
      s2_py_q   <= {32'd0, dmag_y} * {32'd0, inv_cell_q};
      s2_negx_q <= s1_dx_q[CoordW] && (inv_cell_q != 32'd0);
      s2_negy_q <= s1_dy_q[CoordW] && (inv_cell_q != 32'd0);
      s2_h_q    <= s1_h_q;
      s2_nd_q   <= s1_nd_q;
    end
  end

  // stage 3: bounds, fractions, row products, squares
  logic [63:0]         gxi, gyi;
  logic                oob;
  logic [FracBits-1:0] fx, fy;
  logic [FracBits:0]   omfx, omfy;

  assign gxi  = s2_px_q >> (2 * FracBits);
  assign gyi  = s2_py_q >> (2 * FracBits);
  assign oob  = s2_negx_q || s2_negy_q || (grid_w_q < 16'd2) || (grid_h_q < 16'd2) ||
                (gxi >= {48'd0, grid_w_q - 16'd1}) || (gyi >= {48'd0, grid_h_q - 16'd1});
  assign fx   = s2_px_q[2*FracBits-1:FracBits];
  assign fy   = s2_py_q[2*FracBits-1:FracBits];
  assign omfx = One - {1'b0, fx};
  assign omfy = One - {1'b0, fy};

  logic signed [PW-1:0]      s3_p_q [4];
  logic [SqW-1:0]            s3_sfx_q, s3_sox_q, s3_sfy_q, s3_soy_q;
  logic [FracBits:0]         s3_fy_q, s3_omfy_q;
  logic                      s3_oob_q;
  logic signed [HeightW-1:0] s3_h_q [4];
  logic [3:0]                s3_nd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_p_q[0] <= s2_h_q[0] * $signed({1'b0, omfx});
      s3_p_q[1] <= s2_h_q[1] * $signed({2'b0, fx});
      s3_p_q[2] <= s2_h_q[2] * $signed({1'b0, omfx});
      s3_p_q[3] <= s2_h_q[3] * $signed({2'b0, fx});
      s3_sfx_q  <= {1'b0, fx} * {1'b0, fx};
      s3_sox_q  <= omfx * omfx;
      s3_sfy_q  <= {1'b0, fy} * {1'b0, fy};
      s3_soy_q  <= omfy * omfy;
      s3_fy_q   <= {1'b0, fy};
      s3_omfy_q <= omfy;
      s3_oob_q  <= oob;
      s3_h_q    <= s2_h_q;
      s3_nd_q   <= s2_nd_q;
    end
  end

  // stage 4: row blends, nearest valid corner
  logic signed [PW:0]        r0, r1;
  logic [DW-1:0]             sqd [4];
  logic [DW-1:0]             best;
  logic                      found;
  logic signed [HeightW-1:0] near;

  assign r0 = s3_p_q[0] + s3_p_q[1] + Half;
  assign r1 = s3_p_q[2] + s3_p_q[3] + Half;
  assign sqd[0] = {1'b0, s3_sfx_q} + {1'b0, s3_sfy_q};
  assign sqd[1] = {1'b0, s3_sox_q} + {1'b0, s3_sfy_q};
  assign sqd[2] = {1'b0, s3_sfx_q} + {1'b0, s3_soy_q};
  assign sqd[3] = {1'b0, s3_sox_q} + {1'b0, s3_soy_q};

  always_comb begin
    best  = '0;
    found = 1'b0;
    near  = nodata_q;
    for (int i = 0; i < 4; i++) begin
      if (!s3_nd_q[i] && (!found || sqd[i] < best)) begin
        found = 1'b1;
        best  = sqd[i];
        near  = s3_h_q[i];
      end
    end
  end

  logic signed [HeightW-1:0] s4_h0_q, s4_h1_q, s4_near_q;
  logic [FracBits:0]         s4_fy_q, s4_omfy_q;
  logic                      s4_oob_q, s4_nd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_h0_q   <= r0[FracBits +: HeightW];
      s4_h1_q   <= r1[FracBits +: HeightW];
      s4_near_q <= near;
      s4_fy_q   <= s3_fy_q;
      s4_omfy_q <= s3_omfy_q;
      s4_oob_q  <= s3_oob_q;
      s4_nd_q   <= |s3_nd_q;
    end
  end

  // stage 5: column products
  logic signed [PW-1:0]      s5_q0_q, s5_q1_q;
  logic signed [HeightW-1:0] s5_near_q;
  logic                      s5_oob_q, s5_nd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q0_q   <= s4_h0_q * $signed({1'b0, s4_omfy_q});
      s5_q1_q   <= s4_h1_q * $signed({1'b0, s4_fy_q});
      s5_near_q <= s4_near_q;
      s5_oob_q  <= s4_oob_q;
      s5_nd_q   <= s4_nd_q;
    end
  end

  // stage 6: column blend, result select
  logic signed [PW:0]        rc;
  logic [HeightW-1:0]        out_d;
  logic [HeightW-1:0]        out_q;
  logic [1:0]                user_q;

  assign rc = s5_q0_q + s5_q1_q + Half;

  always_comb begin
    priority if (s5_oob_q) begin
      out_d = '0;
    end else if (s5_nd_q) begin
      out_d = s5_near_q;
    end else begin
      out_d = rc[FracBits +: HeightW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      user_q <= {s5_nd_q && !s5_oob_q, s5_oob_q};
    end
  end

  assign m_axis_tdata = out_q;
  assign m_axis_tuser = user_q;

  a_oob_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("out_of_bounds and used_nearest both set");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("out of bounds beat with nonzero height");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && en) |=> vo_q)
    else $error("beat lost at output stage");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q}))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

@@ dv/bilinear_height_sampler_nodata_tb.sv @@
`timescale 1ns / 1ps

module bilinear_height_sampler_nodata_tb;
  import bhs_pkg::*;

  localparam int FB       = FracBitsDef;
  localparam longint ONE  = longint'(1) << FB;
  localparam longint HALF = ONE / 2;
  localparam int Q1       = 1 << FB;
  localparam int WATCHDOG = 5000;
  localparam int SQUEEZE  = 300;

  typedef struct {
    int          base_x;
    int          base_y;
    int unsigned inv_cell;
    logic [15:0] grid_w;
    logic [15:0] grid_h;
    int          nodata;
  } grid_cfg_t;

  typedef struct {
    logic [31:0] height;
    logic        oob;
    logic        nearest;
  } height_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // world_x, world_y, corner_00, corner_10, corner_01, corner_11
  logic [191:0]        s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // height
  logic [HeightW-1:0]  m_axis_tdata;
  // out_of_bounds, used_nearest
  logic [1:0]          m_axis_tuser;

  grid_cfg_t    grid_cfg;
  logic [191:0] pending_queries[$];
  height_t      expected_heights[$];
  height_t      want;
  int           n_queued     = 0;
  int           n_accepted   = 0;
  int           n_results    = 0;
  int           n_errors     = 0;
  int           tx_gap       = 0;
  int           rx_hold      = 0;
  int           stall_cycles = 0;
  bit           calm         = 1'b0;
  bit           squeeze_req  = 1'b0;

  bilinear_height_sampler_nodata i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // grid coordinate along one axis; 0 when the point falls outside
  function automatic logic map_axis(input longint diff, input int unsigned inv,
                                    input logic [15:0] size, output longint g);
    logic [127:0] prod;
    g = 0;
    if (size < 2) return 1'b0;
    if (diff < 0 && inv != 0) return 1'b0;
    if (diff < 0) diff = 0;
    prod = (128'(diff) * 128'(inv)) >> FB;
    if (prod >= ((128'(size) - 128'd1) << FB)) return 1'b0;
    g = longint'(prod);
    return 1'b1;
  endfunction

  function automatic height_t sample_height(input grid_cfg_t c, input logic [191:0] q);
    height_t r;
    int      h[4];
    longint  gx, gy, fx, fy, ax, ay, d2, best, h0, h1;
    logic    in_x, in_y, any_nd, found;
    r.height  = '0;
    r.oob     = 1'b0;
    r.nearest = 1'b0;
    any_nd    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      h[i] = q[64+32*i +: 32];
      if (h[i] == c.nodata) any_nd = 1'b1;
    end
    in_x = map_axis(longint'(int'(q[31:0])) - longint'(c.base_x), c.inv_cell,
                    c.grid_w, gx);
    in_y = map_axis(longint'(c.base_y) - longint'(int'(q[63:32])), c.inv_cell,
                    c.grid_h, gy);
    if (!(in_x && in_y)) begin
      r.oob = 1'b1;
      return r;
    end
    fx = gx & (ONE - 1);
    fy = gy & (ONE - 1);
    if (any_nd) begin
      r.nearest = 1'b1;
      r.height  = c.nodata;
      found     = 1'b0;
      best      = 0;
      for (int i = 0; i < 4; i++) begin
        if (h[i] != c.nodata) begin
          ax = i[0] ? ONE - fx : fx;
          ay = i[1] ? ONE - fy : fy;
          d2 = ax * ax + ay * ay;
          if (!found || d2 < best) begin
            found    = 1'b1;
            best     = d2;
            r.height = h[i];
          end
        end
      end
    end else begin
      h0 = (longint'(h[0]) * (ONE - fx) + longint'(h[1]) * fx + HALF) >>> FB;
      h1 = (longint'(h[2]) * (ONE - fx) + longint'(h[3]) * fx + HALF) >>> FB;
      r.height = 32'((h0 * (ONE - fy) + h1 * fy + HALF) >>> FB);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // world distance from the origin, mostly inside the interpolable span
  function automatic longint pick_dist(input logic [15:0] size, input int unsigned inv);
    longint span;
    if (size < 2) span = ONE;
    else if (inv == 0) span = longint'(1) << 32;
    else span = ((longint'(size) - 1) << 32) / longint'(inv);
    if (span > (longint'(1) << 32)) span = longint'(1) << 32;
    if ($urandom_range(99) < 80) return longint'({$urandom, $urandom} % span);
    case ($urandom_range(4))
      0:       return 0;
      1:       return -1;
      2:       return span - 1;
      3:       return span;
      default: return span + 1;
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(2, 64));
    if (r < 90) return 16'($urandom_range(2, 32768));
    if (r < 95) return 16'($urandom_range(1));
    return 16'($urandom_range(32769, 65535));
  endfunction

  function automatic logic [191:0] query(input int wx, wy, c00, c10, c01, c11);
    return {c11, c01, c10, c00, wy, wx};
  endfunction

  function automatic logic [191:0] make_query(input grid_cfg_t c);
    longint wx, wy;
    int     h[4];
    int     mode;
    wx = longint'(c.base_x) + pick_dist(c.grid_w, c.inv_cell);
    wy = longint'(c.base_y) - pick_dist(c.grid_h, c.inv_cell);
    if (wx > 64'sh7FFF_FFFF || wx < -64'sh8000_0000 || $urandom_range(99) < 8)
      wx = int'($urandom);
    if (wy > 64'sh7FFF_FFFF || wy < -64'sh8000_0000 || $urandom_range(99) < 8)
      wy = int'($urandom);
    mode = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(11))
        0:       h[i] = 32'h7FFF_FFFF;
        1:       h[i] = 32'h8000_0000;
        default: h[i] = $urandom;
      endcase
      if (mode >= 92 || (mode >= 50 && $urandom_range(99) < 35)) h[i] = c.nodata;
    end
    return query(int'(wx), int'(wy), h[0], h[1], h[2], h[3]);
  endfunction

  function automatic grid_cfg_t rand_cfg();
    grid_cfg_t c;
    c.base_x = $urandom_range(1) ? int'($urandom)
                                 : int'($urandom_range(0, 1 << 24)) - (1 << 23);
    c.base_y = $urandom_range(1) ? int'($urandom)
                                 : int'($urandom_range(0, 1 << 24)) - (1 << 23);
    case ($urandom_range(3))
      0:       c.inv_cell = 32'd65536;
      1:       c.inv_cell = $urandom_range(1 << 12, 1 << 20);
      2:       c.inv_cell = $urandom;
      default: c.inv_cell = $urandom_range(1, 3);
    endcase
    c.grid_w = pick_dim();
    c.grid_h = pick_dim();
    c.nodata = $urandom_range(1) ? 32'h8000_0000 : $urandom;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    n_errors++;
    if (n_errors <= 40)
      $display("mismatch %s: got %h, want %h (beat %0d)", what, got, exp_val, n_results);
  endtask

  task automatic enqueue(input logic [191:0] q);
    pending_queries = {pending_queries, q};
    n_queued++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || expected_heights.size() != 0) @(posedge clk_i);
  endtask

  // block is idle here; upper bits of the dimension writes are don't-care
  task automatic load_config(input grid_cfg_t c);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= RegOriginX;
    cfg_data_i <= c.base_x;
    @(posedge clk_i);
    cfg_addr_i <= RegOriginY;
    cfg_data_i <= c.base_y;
    @(posedge clk_i);
    cfg_addr_i <= RegInvCell;
    cfg_data_i <= c.inv_cell;
    @(posedge clk_i);
    cfg_addr_i <= RegGridW;
    cfg_data_i <= {16'($urandom), c.grid_w};
    @(posedge clk_i);
    cfg_addr_i <= RegGridH;
    cfg_data_i <= {16'($urandom), c.grid_h};
    @(posedge clk_i);
    cfg_addr_i <= RegNodata;
    cfg_data_i <= c.nodata;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    grid_cfg = c;
  endtask

  task automatic run_phase(input grid_cfg_t c, input int n);
    load_config(c);
    repeat (n) enqueue(make_query(c));
    drain();
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_heights = {expected_heights, sample_height(grid_cfg, s_axis_tdata)};
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          s_axis_tdata  <= pending_queries.pop_front();
          s_axis_tvalid <= 1'b1;
          tx_gap = calm ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_heights.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          want = expected_heights.pop_front();
          if (m_axis_tdata !== want.height)
            report_mismatch("height", m_axis_tdata, want.height);
          if (m_axis_tuser[0] !== want.oob)
            report_mismatch("out_of_bounds", 32'(m_axis_tuser[0]), 32'(want.oob));
          if (m_axis_tuser[1] !== want.nearest)
            report_mismatch("used_nearest", 32'(m_axis_tuser[1]), 32'(want.nearest));
        end
      end
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        rx_hold     = SQUEEZE;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (calm) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_hold = pick_gap();
        m_axis_tready <= (rx_hold == 0);
        if (rx_hold > 0) rx_hold--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    grid_cfg_t c;
    int        nd;
    grid_cfg = '{int'(OriginRst), int'(OriginRst), InvCellRst, GridDimRst, GridDimRst,
                 int'(NodataRst)};
    nd = NodataRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: unit cells, 1024 x 1024, gx = x and gy = -y
    enqueue(query(0, 0, Q1, 2 * Q1, 3 * Q1, 4 * Q1));
    enqueue(query(Q1 / 2, -Q1 / 2, 0, 1, 0, 1));
    enqueue(query(Q1 / 2, -Q1 / 2, -1, 0, -1, 0));
    enqueue(query(32'h0001_2345, -32'sh6789, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF));
    enqueue(query(Q1 / 4, -3 * Q1 / 4, 32'h8000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0001));
    enqueue(query(2 * Q1 + 5, -7 * Q1 - 9, 32'h8000_0001, 32'h8000_0001,
                  32'h8000_0001, 32'h8000_0001));
    enqueue(query(-1, 0, 1, 2, 3, 4));
    enqueue(query(0, 1, 1, 2, 3, 4));
    enqueue(query(1023 * Q1, 0, 1, 2, 3, 4));
    enqueue(query(1023 * Q1 - 1, -(1023 * Q1 - 1), $urandom, $urandom, $urandom,
                  $urandom));
    enqueue(query(0, -1023 * Q1, 1, 2, 3, 4));
    enqueue(query(32'h7FFF_FFFF, 32'h8000_0000, 1, 2, 3, 4));
    enqueue(query(32'h8000_0000, 32'h7FFF_FFFF, 1, 2, 3, 4));
    // nearest-valid fallback, including distance ties
    enqueue(query(Q1 / 2, -Q1 / 2, nd, 5, 6, 7));
    enqueue(query(Q1 / 4, -Q1 / 4, nd, 5, 6, 7));
    enqueue(query(3 * Q1 / 4, -Q1 / 4, 1, nd, 3, 4));
    enqueue(query(Q1 / 3, -Q1 / 5, nd, nd, nd, 9));
    enqueue(query(Q1 / 3, -Q1 / 5, nd, nd, nd, nd));
    enqueue(query(-1, 0, nd, 2, 3, 4));
    enqueue(query(3 * Q1 + 17, -(5 * Q1 + 3), 1, 2, nd, 4));
    drain();

    // small grid with half-size cells while the output side stalls
    squeeze_req = 1'b1;
    run_phase('{-(5 * Q1), 3 * Q1, 32'd131072, 16'd4, 16'd4, 0}, 150);

    run_phase('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd32768, 16'd32768,
                32'h7FFF_FFFF}, 150);

    calm = 1'b1;
    run_phase('{$urandom, $urandom, 32'd0, 16'd2, 16'd2, 32'h8000_0000}, 100);
    calm = 1'b0;

    run_phase('{0, 0, 32'd65536, 16'd1, 16'd0, 0}, 40);

    repeat (7) begin
      c = rand_cfg();
      run_phase(c, 130);
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
